/* rtl/core/xmodem_checksum_receiver_core_macros.svh */
`ifndef XMODEM_CHECKSUM_RECEIVER_CORE_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define XCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define XCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/xcr_pkg.sv */
`default_nettype none

package xcr_pkg;

  localparam int ADDR_WIDTH  = 20;
  localparam int LEN_WIDTH   = ADDR_WIDTH + 1;
  localparam int BLOCK_BYTES = 128;
  localparam int IDX_WIDTH   = $clog2(BLOCK_BYTES);
  localparam int TICK_WIDTH  = 15;

  localparam logic [TICK_WIDTH-1:0] NAK_IDLE_RESET = TICK_WIDTH'(20000);

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] BLK_INV_MATCH = 8'hFF;

  localparam logic [1:0] FINISH_RUNNING = 2'd0;
  localparam logic [1:0] FINISH_OK      = 2'd1;
  localparam logic [1:0] FINISH_FAIL    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                  send_valid;
    logic [7:0]            send_byte;
    logic                  write_valid;
    logic [ADDR_WIDTH-1:0] write_address;
    logic [7:0]            write_data;
    logic [1:0]            finish_status;
    logic [LEN_WIDTH-1:0]  received_length;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/xcr_in_stage.sv */
`default_nettype none

module xcr_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire xcr_pkg::item_t in_data_i,
  input  wire logic          take_i,
  output      logic          item_valid_o,
  output      xcr_pkg::item_t item_o
);

  logic           valid_q;
  xcr_pkg::item_t item_q;

  assign in_stall_o   = valid_q & ~take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/xcr_out_stage.sv */
`default_nettype none

module xcr_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire xcr_pkg::result_t result_i,
  output      logic             ready_o,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      xcr_pkg::result_t out_data_o
);

  logic             valid_q;
  xcr_pkg::result_t data_q;

  assign ready_o     = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/xcr_engine.sv */
`default_nettype none

`include "xmodem_checksum_receiver_core_macros.svh"

module xcr_engine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [xcr_pkg::TICK_WIDTH-1:0]     cfg_wdata_i,
  input  wire logic                               fire_i,
  input  wire xcr_pkg::item_t                     item_i,
  output      xcr_pkg::result_t                   result_o
);

  localparam logic [2:0] PH_CTRL      = 3'd0;
  localparam logic [2:0] PH_BLK       = 3'd1;
  localparam logic [2:0] PH_BLK_INV   = 3'd2;
  localparam logic [2:0] PH_DATA      = 3'd3;
  localparam logic [2:0] PH_SUM       = 3'd4;
  localparam logic [2:0] PH_DONE_OK   = 3'd5;
  localparam logic [2:0] PH_DONE_FAIL = 3'd6;

  localparam int LW = xcr_pkg::LEN_WIDTH;
  localparam int AW = xcr_pkg::ADDR_WIDTH;
  localparam int IW = xcr_pkg::IDX_WIDTH;
  localparam int TW = xcr_pkg::TICK_WIDTH;

  localparam logic [LW:0]   BufSize  = {2'b01, {AW{1'b0}}};
  localparam logic [IW-1:0] LastIdx  = IW'(xcr_pkg::BLOCK_BYTES - 1);

  logic [TW-1:0] nak_ticks_q;
  logic [2:0]    phase_q, phase_d;
  logic [7:0]    exp_blk_q, exp_blk_d;
  logic [7:0]    rcv_blk_q, rcv_blk_d;
  logic [IW-1:0] byte_idx_q, byte_idx_d;
  logic [7:0]    sum_q, sum_d;
  logic [LW-1:0] total_q, total_d;
  logic [TW-1:0] idle_q, idle_d;

  logic          overflow;
  logic [7:0]    rx;
  xcr_pkg::result_t res;

  assign rx       = item_i.rx_byte;
  assign overflow = ({1'b0, total_q} + (LW+1)'(xcr_pkg::BLOCK_BYTES)) > BufSize;

  always_comb begin
    phase_d    = phase_q;
    exp_blk_d  = exp_blk_q;
    rcv_blk_d  = rcv_blk_q;
    byte_idx_d = byte_idx_q;
    sum_d      = sum_q;
    total_d    = total_q;
    idle_d     = idle_q;
    res        = '0;

    case (item_i.kind)
      xcr_pkg::KIND_RESTART: begin
        phase_d    = PH_CTRL;
        exp_blk_d  = 8'd1;
        rcv_blk_d  = '0;
        byte_idx_d = '0;
        sum_d      = '0;
        total_d    = '0;
        idle_d     = '0;
      end
      xcr_pkg::KIND_TICK: begin
        if (phase_q == PH_CTRL && total_q == '0) begin
          if (idle_q >= nak_ticks_q) begin
            idle_d         = '0;
            res.send_valid = 1'b1;
            res.send_byte  = xcr_pkg::CH_NAK;
          end else begin
            idle_d = idle_q + TW'(1);
          end
        end
      end
      xcr_pkg::KIND_BYTE: begin
        case (phase_q)
          PH_CTRL: begin
            idle_d = '0;
            if (rx == xcr_pkg::CH_CAN) begin
              phase_d = PH_DONE_FAIL;
            end else if (rx == xcr_pkg::CH_EOT) begin
              res.send_valid = 1'b1;
              res.send_byte  = xcr_pkg::CH_ACK;
              phase_d        = PH_DONE_OK;
            end else if (rx == xcr_pkg::CH_SOH) begin
              phase_d = overflow ? PH_DONE_FAIL : PH_BLK;
            end else if (total_q != '0) begin
              phase_d = PH_DONE_FAIL;
            end
          end
          PH_BLK: begin
            if (rx != exp_blk_q) begin
              res.send_valid = 1'b1;
              res.send_byte  = xcr_pkg::CH_NAK;
              phase_d        = PH_CTRL;
            end else begin
              rcv_blk_d = rx;
              phase_d   = PH_BLK_INV;
            end
          end
          PH_BLK_INV: begin
            if ((rcv_blk_q ^ rx) != xcr_pkg::BLK_INV_MATCH) begin
              res.send_valid = 1'b1;
              res.send_byte  = xcr_pkg::CH_NAK;
              phase_d        = PH_CTRL;
            end else begin
              byte_idx_d = '0;
              sum_d      = '0;
              phase_d    = PH_DATA;
            end
          end
          PH_DATA: begin
            res.write_valid   = 1'b1;
            res.write_address = total_q[AW-1:0] + AW'(byte_idx_q);
            res.write_data    = rx;
            sum_d             = sum_q + rx;
            if (byte_idx_q == LastIdx) begin
              byte_idx_d = '0;
              phase_d    = PH_SUM;
            end else begin
              byte_idx_d = byte_idx_q + IW'(1);
            end
          end
          PH_SUM: begin
            res.send_valid = 1'b1;
            if (sum_q == rx) begin
              exp_blk_d     = exp_blk_q + 8'd1;
              total_d       = total_q + LW'(xcr_pkg::BLOCK_BYTES);
              res.send_byte = xcr_pkg::CH_ACK;
            end else begin
              res.send_byte = xcr_pkg::CH_NAK;
            end
            phase_d = PH_CTRL;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.finish_status   = (phase_d == PH_DONE_OK)   ? xcr_pkg::FINISH_OK   :
                          (phase_d == PH_DONE_FAIL) ? xcr_pkg::FINISH_FAIL :
                                                      xcr_pkg::FINISH_RUNNING;
    res.received_length = total_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nak_ticks_q <= xcr_pkg::NAK_IDLE_RESET;
    end else if (cfg_we_i) begin
      nak_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CTRL;
      exp_blk_q  <= 8'd1;
      rcv_blk_q  <= '0;
      byte_idx_q <= '0;
      sum_q      <= '0;
      total_q    <= '0;
      idle_q     <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      exp_blk_q  <= exp_blk_d;
      rcv_blk_q  <= rcv_blk_d;
      byte_idx_q <= byte_idx_d;
      sum_q      <= sum_d;
      total_q    <= total_d;
      idle_q     <= idle_d;
    end
  end

  `XCR_ASSERT_IMPL(a_write_only_in_data, fire_i && res.write_valid, phase_q == PH_DATA, "data write outside data phase")
  `XCR_ASSERT_IMPL(a_send_is_ack_or_nak, res.send_valid, res.send_byte == xcr_pkg::CH_ACK || res.send_byte == xcr_pkg::CH_NAK, "bad send byte")
  `XCR_ASSERT_IMPL(a_len_block_aligned, 1'b1, total_q[IW-1:0] == '0, "length not block aligned")
  `XCR_ASSERT_NEXT(a_done_sticks, fire_i && phase_q == PH_DONE_OK && item_i.kind != xcr_pkg::KIND_RESTART, phase_q == PH_DONE_OK, "left finished state without restart")

endmodule

`default_nettype wire

/* rtl/core/xmodem_checksum_receiver_core.sv */
`default_nettype none

// XMODEM receiver (8-bit checksum, 128-byte SOH blocks). Each input transaction
// is an idle tick, a received byte or a restart, and yields exactly one result
// transaction carrying an optional ACK/NAK to send, an optional buffer write,
// the finish status and the received length. Transactions pass through an input
// register, a combinational state update and an output register, so the core
// takes one transaction per clock unless out_stall_i holds the output;
// out_valid_o rises once a transaction has moved from the input register into
// the output register, whose stall backs up into in_stall_o in the same cycle.
// nak_idle_ticks (cfg_wdata_i, reset 20000) may be written only while idle.

module xmodem_checksum_receiver_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [xcr_pkg::TICK_WIDTH-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire xcr_pkg::item_t                 in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      xcr_pkg::result_t               out_data_o
);

  logic             item_valid;
  xcr_pkg::item_t   item;
  logic             out_ready;
  logic             fire;
  xcr_pkg::result_t result;

  assign fire = item_valid & out_ready;

  xcr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (out_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  xcr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .result_o    (result)
  );

  xcr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
